[rtl/lfc_pkg.sv]
// Shared constants for the log format classifier: format codes, register
// addresses, line feature bits, signature bytes and the tag/month lookups.
// No dependencies.
package lfc_pkg;

	// format codes
	typedef enum logic [3:0] {
		FMT_UNKNOWN   = 4'd0,
		FMT_EVENTLOG  = 4'd1,
		FMT_CAPTURE   = 4'd2,
		FMT_ZIP       = 4'd3,
		FMT_CEF       = 4'd4,
		FMT_SYSLOG    = 4'd5,
		FMT_JSON      = 4'd6,
		FMT_W3C       = 4'd7,
		FMT_ACCESSLOG = 4'd8,
		FMT_CSV       = 4'd9
	} fmt_t;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_MIN_VOTES   = 2'd0;
	localparam logic [1:0] REG_CSV_MIN     = 2'd1;
	localparam logic [1:0] REG_MAX_SAMPLES = 2'd2;

	// per-line feature bits
	localparam int LF_STARTED  = 0;
	localparam int LF_QUOTED   = 1;
	localparam int LF_FIELDS   = 2;
	localparam int LF_SOFT     = 3;
	localparam int LF_PREFIX   = 4;
	localparam int LF_DOT      = 5;
	localparam int LF_SPACE    = 6;
	localparam int LF_SPACE_OK = 7;
	localparam int LF_BRACKET  = 8;
	localparam int LF_QUOTE    = 9;
	localparam int LF_CEF      = 10;
	localparam int LF_W        = 11;

	localparam logic [LF_W-1:0] LF_CLEAR =
		(LF_W'(1) << LF_FIELDS) | (LF_W'(1) << LF_SOFT) | (LF_W'(1) << LF_PREFIX);
	localparam logic [LF_W-1:0] LF_NEED =
		(LF_W'(1) << LF_BRACKET) | (LF_W'(1) << LF_QUOTE) | (LF_W'(1) << LF_SPACE) |
		(LF_W'(1) << LF_SPACE_OK) | (LF_W'(1) << LF_PREFIX) | (LF_W'(1) << LF_DOT);

	// characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;
	localparam logic [23:0] CEF_WIN = 24'h434546;

	// signatures (the 64-bit one holds header byte 0 in the low bits, the 32-bit ones in the high bits)
	localparam logic [63:0] SIG_EVENTLOG = 64'h00656C6946666C45;
	localparam logic [31:0] SIG_CAP_LE   = 32'hD4C3B2A1;
	localparam logic [31:0] SIG_CAP_BE   = 32'hA1B2C3D4;
	localparam logic [31:0] SIG_CAP_NG   = 32'h0A0D0D0A;
	localparam logic [31:0] SIG_ZIP      = 32'h504B0304;

	localparam logic [63:0]  FIELDS_TAG = "#Fields:";
	localparam logic [79:0]  SOFT_TAG   = "#Software:";
	localparam logic [287:0] MONTHS     = "JanFebMarAprMayJunJulAugSepOctNovDec";

	function automatic logic [7:0] fields_char(input logic [2:0] i);
		return FIELDS_TAG[8*(7-int'(i)) +: 8];
	endfunction

	function automatic logic [7:0] soft_char(input logic [3:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (i < 4'd10)
			r = SOFT_TAG[8*(9-int'(i)) +: 8];
		return r;
	endfunction

	function automatic logic num_char(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// first three characters spell a month abbreviation
	function automatic logic is_month(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2);
		logic hit;
		hit = 1'b0;
		for (int m = 0; m < 12; m++) begin
			if ({c0, c1, c2} == MONTHS[24*(11-m) +: 24])
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

[rtl/log_format_classifier.sv]
// Log format classifier top level: input register, per-byte line and vote
// update, and the format decision on a file's last byte. Uses lfc_pkg.
// Result path: format_code is valid once a file's last byte has passed the input
// register and then the result register, and later only while an earlier
// result is still held on a stalled output.
// Throughput: one byte per cycle; the input stalls only while a last byte waits
// for a result still held on a stalled output.
// Reset (arst_n low): registers take 2/3/50, all file and line state clears.
// Each file's result also clears the file state for the next byte.
module log_format_classifier #(
	parameter int SCAN_BYTES = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            format_code,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import lfc_pkg::*;

	localparam int CW = $clog2(SCAN_BYTES + 1);
	localparam logic [CW-1:0] SCAN_LIM = CW'(SCAN_BYTES);

	// configuration
	logic [5:0] min_votes_q, csv_min_q, max_samples_q;
	logic       cfg_wr;

	// input stage
	logic       valid_s1, last_s1;
	logic [7:0] byte_s1;
	logic       go;

	// file and line state
	logic [63:0]     hdr_q, n_hdr;
	logic [3:0]      total_q, n_total;
	logic [CW-1:0]   scan_q, n_scan;
	logic [CW-1:0]   len_q, n_len;
	logic [23:0]     first_q, n_first;
	logic [7:0]      lastns_q, n_lastns;
	logic [23:0]     tag_q, n_tag;
	logic [LF_W-1:0] flags_q, n_flags;
	logic [CW-1:0]   delim_q [3];
	logic [CW-1:0]   n_delim [3];
	logic [CW-1:0]   ptabs_q, n_ptabs;
	logic [CW-1:0]   spos_q, n_spos;
	logic [5:0]      votes_q [5];
	logic [5:0]      n_votes [5];
	logic [1:0]      choice_q, n_choice;
	logic [CW-1:0]   ref_q, n_ref;
	logic [5:0]      csvl_q, n_csvl;
	logic [5:0]      lines_q, n_lines;
	logic            w3c_q, n_w3c;

	// output register
	logic       out_valid_q;
	fmt_t       code_q, n_code;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_votes_q   <= 6'd2;
			csv_min_q     <= 6'd3;
			max_samples_q <= 6'd50;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MIN_VOTES:   min_votes_q   <= pwdata[5:0];
				REG_CSV_MIN:     csv_min_q     <= pwdata[5:0];
				REG_MAX_SAMPLES: max_samples_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MIN_VOTES:   prdata = {26'd0, min_votes_q};
			REG_CSV_MIN:     prdata = {26'd0, csv_min_q};
			REG_MAX_SAMPLES: prdata = {26'd0, max_samples_q};
			default:         prdata = 32'd0;
		endcase
	end

	// handshake: a last byte moves on only when the output slot frees
	assign go       = !last_s1 || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// per-byte update: header, character features, line end, decision, end-of-file clear
	always_comb begin
		logic [7:0]  c;
		logic        blank, in_scan, do_end, skip;
		logic [CW-1:0] pos;
		logic [5:0]  limit;
		logic [7:0]  c0, c1, c2;

		n_hdr    = hdr_q;
		n_total  = total_q;
		n_scan   = scan_q;
		n_len    = len_q;
		n_first  = first_q;
		n_lastns = lastns_q;
		n_tag    = tag_q;
		n_flags  = flags_q;
		n_ptabs  = ptabs_q;
		n_spos   = spos_q;
		n_choice = choice_q;
		n_ref    = ref_q;
		n_csvl   = csvl_q;
		n_lines  = lines_q;
		n_w3c    = w3c_q;
		for (int i = 0; i < 3; i++) n_delim[i] = delim_q[i];
		for (int i = 0; i < 5; i++) n_votes[i] = votes_q[i];

		c     = byte_s1;
		blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
		pos   = len_q;
		skip  = 1'b0;

		// header capture
		if (total_q < 4'd8) begin
			n_hdr[{total_q[2:0], 3'b000} +: 8] = c;
			n_total = total_q + 4'd1;
		end

		in_scan = scan_q < SCAN_LIM;
		if (in_scan)
			n_scan = scan_q + CW'(1);

		// character features
		if (in_scan && c != CH_LF) begin
			if (c == CH_COLON && tag_q == CEF_WIN)
				n_flags[LF_CEF] = 1'b1;
			n_tag = {tag_q[15:0], c};
			if (!flags_q[LF_STARTED]) begin
				if (blank)
					skip = 1'b1;
				else
					n_flags[LF_STARTED] = 1'b1;
			end
			if (!skip) begin
				if (pos < CW'(3))
					n_first[{pos[1:0], 3'b000} +: 8] = first_q[{pos[1:0], 3'b000} +: 8] | c;
				if (pos < CW'(8) && c != fields_char(pos[2:0]))
					n_flags[LF_FIELDS] = 1'b0;
				if (pos < CW'(10) && c != soft_char(pos[3:0]))
					n_flags[LF_SOFT] = 1'b0;

				// access-log prefix: digits, dots and colons up to the first space
				if (!flags_q[LF_SPACE]) begin
					if (c == CH_SP) begin
						n_flags[LF_SPACE] = 1'b1;
						n_spos = pos;
					end else if (c == CH_DOT) begin
						n_flags[LF_DOT] = 1'b1;
					end else if (!num_char(c) && c != CH_COLON) begin
						n_flags[LF_PREFIX] = 1'b0;
					end
				end else if (!blank) begin
					n_flags[LF_SPACE_OK] = 1'b1;
				end

				if (c == CH_LBRK && !flags_q[LF_QUOTE])
					n_flags[LF_BRACKET] = 1'b1;

				// quote-aware delimiter counts; tabs wait until a non-blank follows
				if (c == CH_QUOTE) begin
					n_flags[LF_QUOTE]  = 1'b1;
					n_flags[LF_QUOTED] = !flags_q[LF_QUOTED];
				end else if (!flags_q[LF_QUOTED]) begin
					if (c == CH_COMMA)
						n_delim[0] = delim_q[0] + CW'(1);
					else if (c == CH_SEMI)
						n_delim[2] = delim_q[2] + CW'(1);
					else if (c == CH_TAB)
						n_ptabs = ptabs_q + CW'(1);
				end

				if (!blank) begin
					n_delim[1] = delim_q[1] + n_ptabs;
					n_ptabs    = '0;
					n_lastns   = c;
				end
				if (len_q < SCAN_LIM)
					n_len = len_q + CW'(1);
			end
		end

		// line end: vote on the finished line
		do_end = (in_scan && c == CH_LF) || last_s1;
		limit  = (max_samples_q == 6'd0) ? 6'd1 : max_samples_q;
		c0 = n_first[7:0];
		c1 = n_first[15:8];
		c2 = n_first[23:16];
		if (do_end) begin
			if (n_flags[LF_STARTED] && n_lines < limit) begin
				n_lines = n_lines + 6'd1;
				if (n_flags[LF_CEF])
					n_votes[0] = n_votes[0] + 6'd1;
				if (c0 == CH_LT && num_char(c1))
					n_votes[1] = n_votes[1] + 6'd1;
				if (is_month(c0, c1, c2))
					n_votes[2] = n_votes[2] + 6'd1;
				if (c0 == CH_LBRC && n_lastns == CH_RBRC)
					n_votes[3] = n_votes[3] + 6'd1;
				if ((n_flags[LF_FIELDS] && n_len >= CW'(8)) ||
						(n_flags[LF_SOFT] && n_len >= CW'(10)))
					n_w3c = 1'b1;
				if ((n_flags & LF_NEED) == LF_NEED && n_spos >= CW'(7))
					n_votes[4] = n_votes[4] + 6'd1;
				if (c0 != CH_HASH) begin
					for (int i = 0; i < 3; i++) begin
						if (n_delim[i] != '0) begin
							if (n_choice == 2'd0) begin
								n_choice = 2'(i + 1);
								n_ref    = n_delim[i];
								n_csvl   = 6'd1;
							end else if (n_choice == 2'(i + 1) && n_delim[i] == n_ref) begin
								if (n_csvl < 6'd63)
									n_csvl = n_csvl + 6'd1;
							end
						end
					end
				end
			end
			n_len    = '0;
			n_first  = '0;
			n_lastns = '0;
			n_tag    = '0;
			n_flags  = LF_CLEAR;
			n_ptabs  = '0;
			n_spos   = '0;
			for (int i = 0; i < 3; i++) n_delim[i] = '0;
		end

		// decision by fixed priority
		if (n_total < 4'd4)
			n_code = FMT_UNKNOWN;
		else if (n_total >= 4'd8 && n_hdr == SIG_EVENTLOG)
			n_code = FMT_EVENTLOG;
		else if ({n_hdr[7:0], n_hdr[15:8], n_hdr[23:16], n_hdr[31:24]} == SIG_CAP_LE ||
				{n_hdr[7:0], n_hdr[15:8], n_hdr[23:16], n_hdr[31:24]} == SIG_CAP_BE ||
				{n_hdr[7:0], n_hdr[15:8], n_hdr[23:16], n_hdr[31:24]} == SIG_CAP_NG)
			n_code = FMT_CAPTURE;
		else if ({n_hdr[7:0], n_hdr[15:8], n_hdr[23:16], n_hdr[31:24]} == SIG_ZIP)
			n_code = FMT_ZIP;
		else if (n_lines == 6'd0)
			n_code = FMT_UNKNOWN;
		else if (n_votes[0] >= min_votes_q)
			n_code = FMT_CEF;
		else if (n_votes[1] >= min_votes_q || n_votes[2] >= min_votes_q)
			n_code = FMT_SYSLOG;
		else if (n_votes[3] >= min_votes_q)
			n_code = FMT_JSON;
		else if (n_w3c)
			n_code = FMT_W3C;
		else if (n_votes[4] >= min_votes_q)
			n_code = FMT_ACCESSLOG;
		else if (n_csvl >= csv_min_q)
			n_code = FMT_CSV;
		else
			n_code = FMT_UNKNOWN;

		// end of file: start the next one clean
		if (last_s1) begin
			n_hdr    = '0;
			n_total  = '0;
			n_scan   = '0;
			n_choice = '0;
			n_ref    = '0;
			n_csvl   = '0;
			n_lines  = '0;
			n_w3c    = 1'b0;
			for (int i = 0; i < 5; i++) n_votes[i] = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= '0;
			total_q  <= '0;
			scan_q   <= '0;
			len_q    <= '0;
			first_q  <= '0;
			lastns_q <= '0;
			tag_q    <= '0;
			flags_q  <= LF_CLEAR;
			ptabs_q  <= '0;
			spos_q   <= '0;
			choice_q <= '0;
			ref_q    <= '0;
			csvl_q   <= '0;
			lines_q  <= '0;
			w3c_q    <= 1'b0;
			for (int i = 0; i < 3; i++) delim_q[i] <= '0;
			for (int i = 0; i < 5; i++) votes_q[i] <= '0;
		end else if (valid_s1 && go) begin
			hdr_q    <= n_hdr;
			total_q  <= n_total;
			scan_q   <= n_scan;
			len_q    <= n_len;
			first_q  <= n_first;
			lastns_q <= n_lastns;
			tag_q    <= n_tag;
			flags_q  <= n_flags;
			ptabs_q  <= n_ptabs;
			spos_q   <= n_spos;
			choice_q <= n_choice;
			ref_q    <= n_ref;
			csvl_q   <= n_csvl;
			lines_q  <= n_lines;
			w3c_q    <= n_w3c;
			for (int i = 0; i < 3; i++) delim_q[i] <= n_delim[i];
			for (int i = 0; i < 5; i++) votes_q[i] <= n_votes[i];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (valid_s1 && go && last_s1)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && go && last_s1)
			code_q <= n_code;
	end

	assign out_valid   = out_valid_q;
	assign format_code = code_q;

	// checks
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> code_q <= FMT_CSV)
		else $error("format code out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_q)
		else $error("input stalled without a pending result");

	a_file_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && go && last_s1 |=> lines_q == 6'd0 && total_q == 4'd0 && scan_q == '0)
		else $error("file state not cleared after result");

endmodule

[tb/log_format_classifier_tb.sv]
// Self-checking testbench for log_format_classifier: byte-stream files in, format code out.
// Uses lfc_pkg from the RTL; a behavioral predictor computes each file's expected code.
`timescale 1ns / 100ps

module log_format_classifier_tb;
	import lfc_pkg::*;

	localparam int SCAN_LIMIT  = 65536;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} file_byte_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  format_code;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	log_format_classifier u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall), .format_code(format_code),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	file_byte_t pending_bytes[$];
	fmt_t       expected_codes[$];
	bit [7:0]   fbuf[$];
	int         errors;
	int         cycles;
	bit         calm;
	int         in_gap;
	int         out_gap;

	// classifier shadow: registers and file/line state
	bit [5:0]  cfg_votes, cfg_csv_min, cfg_max_lines;
	bit [63:0] hdr;
	bit [3:0]  seen;
	bit [16:0] scanned, llen, tabs_waiting, sp_pos;
	bit [23:0] first3, win;
	bit [7:0]  last_nb;
	bit [11:0] flags;
	bit [16:0] delims[3];
	bit [5:0]  votes[5];
	bit [2:0]  csv_pick;
	bit [16:0] csv_ref;
	bit [5:0]  csv_cnt, sampled;
	bit        w3c_hit;

	string fields_txt = "#Fields:";
	string soft_str   = "#Software:";
	string month_str  = "JanFebMarAprMayJunJulAugSepOctNovDec";

	function automatic bit blank_char(bit [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR;
	endfunction

	function automatic bit digit_char(bit [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void reset_line();
		llen = 0; first3 = 0; last_nb = 0; win = 0;
		flags = 0;
		flags[LF_FIELDS] = 1; flags[LF_SOFT] = 1; flags[LF_PREFIX] = 1;
		for (int i = 0; i < 3; i++) delims[i] = 0;
		tabs_waiting = 0; sp_pos = 0;
	endfunction

	function automatic void reset_file();
		hdr = 0; seen = 0; scanned = 0;
		for (int i = 0; i < 5; i++) votes[i] = 0;
		csv_pick = 0; csv_ref = 0; csv_cnt = 0; sampled = 0; w3c_hit = 0;
		reset_line();
	endfunction

	function automatic void line_char(bit [7:0] c);
		bit        bl;
		bit [16:0] pos;
		bl = blank_char(c);
		if (c == CH_COLON && win == CEF_WIN) flags[LF_CEF] = 1;
		win = {win[15:0], c};
		if (!flags[LF_STARTED]) begin
			if (bl) return;
			flags[LF_STARTED] = 1;
		end
		pos = llen;
		if (pos < 3) first3 |= 24'(c) << (8 * pos);
		if (pos < 8 && c != fields_txt[pos]) flags[LF_FIELDS] = 0;
		if (pos < 10 && c != soft_str[pos]) flags[LF_SOFT] = 0;
		// access-log prefix: digits, dots and colons up to the first space
		if (!flags[LF_SPACE]) begin
			if (c == CH_SP) begin
				flags[LF_SPACE] = 1;
				sp_pos = pos;
			end else if (c == CH_DOT) begin
				flags[LF_DOT] = 1;
			end else if (!digit_char(c) && c != CH_COLON) begin
				flags[LF_PREFIX] = 0;
			end
		end else if (!bl) begin
			flags[LF_SPACE_OK] = 1;
		end
		if (c == CH_LBRK && !flags[LF_QUOTE]) flags[LF_BRACKET] = 1;
		// quote-aware delimiter counts
		if (c == CH_QUOTE) begin
			flags[LF_QUOTE] = 1;
			flags[LF_QUOTED] = ~flags[LF_QUOTED];
		end else if (!flags[LF_QUOTED]) begin
			if (c == CH_COMMA) delims[0]++;
			else if (c == CH_SEMI) delims[2]++;
			else if (c == CH_TAB) tabs_waiting++;
		end
		if (!bl) begin
			delims[1] += tabs_waiting;
			tabs_waiting = 0;
			last_nb = c;
		end
		if (llen < SCAN_LIMIT) llen++;
	endfunction

	function automatic void close_line();
		bit [5:0]  lim;
		bit [7:0]  c0, c1, c2;
		bit [11:0] need;
		lim = (cfg_max_lines != 0) ? cfg_max_lines : 6'd1;
		c0 = first3[7:0]; c1 = first3[15:8]; c2 = first3[23:16];
		need = 0;
		need[LF_BRACKET] = 1; need[LF_QUOTE] = 1; need[LF_SPACE] = 1;
		need[LF_SPACE_OK] = 1; need[LF_PREFIX] = 1; need[LF_DOT] = 1;
		if (flags[LF_STARTED] && sampled < lim) begin
			sampled++;
			if (flags[LF_CEF]) votes[0]++;
			if (c0 == CH_LT && digit_char(c1)) votes[1]++;
			for (int m = 0; m < 12; m++) begin
				if (c0 == month_str[3*m] && c1 == month_str[3*m+1] &&
						c2 == month_str[3*m+2]) begin
					votes[2]++;
					break;
				end
			end
			if (c0 == CH_LBRC && last_nb == CH_RBRC) votes[3]++;
			if ((flags[LF_FIELDS] && llen >= 8) || (flags[LF_SOFT] && llen >= 10))
				w3c_hit = 1;
			if ((flags & need) == need && sp_pos >= 7) votes[4]++;
			if (c0 != CH_HASH) begin
				for (int i = 0; i < 3; i++) begin
					if (delims[i] == 0) continue;
					if (csv_pick == 0) begin
						csv_pick = 3'(i + 1);
						csv_ref = delims[i];
						csv_cnt = 1;
					end else if (csv_pick == 3'(i + 1) && delims[i] == csv_ref) begin
						if (csv_cnt < 63) csv_cnt++;
					end
				end
			end
		end
		reset_line();
	endfunction

	function automatic fmt_t classify();
		bit [31:0] magic;
		if (seen < 4) return FMT_UNKNOWN;
		if (seen >= 8 && hdr == SIG_EVENTLOG) return FMT_EVENTLOG;
		magic = {hdr[7:0], hdr[15:8], hdr[23:16], hdr[31:24]};
		if (magic == SIG_CAP_LE || magic == SIG_CAP_BE || magic == SIG_CAP_NG)
			return FMT_CAPTURE;
		if (magic == SIG_ZIP) return FMT_ZIP;
		if (sampled == 0) return FMT_UNKNOWN;
		if (votes[0] >= cfg_votes) return FMT_CEF;
		if (votes[1] >= cfg_votes || votes[2] >= cfg_votes) return FMT_SYSLOG;
		if (votes[3] >= cfg_votes) return FMT_JSON;
		if (w3c_hit) return FMT_W3C;
		if (votes[4] >= cfg_votes) return FMT_ACCESSLOG;
		if (csv_cnt >= cfg_csv_min) return FMT_CSV;
		return FMT_UNKNOWN;
	endfunction

	// one accepted byte; queues a code on the file's last byte
	function automatic void predict_byte(bit [7:0] c, bit last);
		if (seen < 8) begin
			hdr |= 64'(c) << (8 * seen);
			seen++;
		end
		if (scanned < SCAN_LIMIT) begin
			scanned++;
			if (c == CH_LF) close_line();
			else line_char(c);
		end
		if (last) begin
			close_line();
			expected_codes.insert(expected_codes.size(), classify());
			reset_file();
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		file_byte_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) predict_byte(data_byte, last_byte);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					nb = pending_bytes.pop_front();
					data_byte <= nb.data;
					last_byte <= nb.last;
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		fmt_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_codes.size() == 0) begin
					report("unexpected transaction", format_code, -1);
				end else begin
					want = expected_codes.pop_front();
					if (format_code !== want) report("format_code", format_code, want);
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_gap = pick_gap();
				out_stall <= (out_gap > 0);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("FAIL log_format_classifier");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, bit [5:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= {$urandom_range(0, 3) << 6} | val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
		case (idx)
			REG_MIN_VOTES:   cfg_votes = val;
			REG_CSV_MIN:     cfg_csv_min = val;
			REG_MAX_SAMPLES: cfg_max_lines = val;
			default: ;
		endcase
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) fbuf.insert(fbuf.size(), s[i]);
	endtask

	// queue the collected bytes as one file
	task automatic send_file();
		file_byte_t fb;
		for (int i = 0; i < fbuf.size(); i++) begin
			fb.data = fbuf[i];
			fb.last = (i == fbuf.size() - 1);
			pending_bytes.insert(pending_bytes.size(), fb);
		end
		fbuf.delete();
	endtask

	function automatic string rand_text(int n);
		string s, pool;
		int k;
		pool = "abcXYZ09 ,;\t\"[:.{}<#";
		s = "";
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, pool.len() - 1);
			s = {s, pool.substr(k, k)};
		end
		return s;
	endfunction

	function automatic string csv_line(int fields, string sep);
		string s;
		s = $sformatf("%0d", $urandom_range(0, 999));
		for (int i = 1; i < fields; i++) begin
			if ($urandom_range(0, 5) == 0) s = {s, sep, "\"q", sep, "x\""};
			else s = {s, sep, rand_text($urandom_range(0, 3))};
		end
		return s;
	endfunction

	function automatic string make_line(int kind, int fields, string sep);
		string s;
		int m;
		m = $urandom_range(0, 11);
		case (kind)
			0: s = $sformatf("CEF:0|v|p|%0d|%s", $urandom_range(0, 9), rand_text(3));
			1: s = $sformatf("<%0d>host %s", $urandom_range(0, 191), rand_text(4));
			2: s = $sformatf("%s %0d 10:0%0d:00 h", month_str.substr(3*m, 3*m+2),
				$urandom_range(1, 31), $urandom_range(0, 9));
			3: s = $sformatf("{\"k\":%0d%s}", $urandom_range(0, 99), rand_text(2));
			4: s = ($urandom_range(0, 1)) ? "#Fields: date time" : "#Software: srv";
			5: s = $sformatf("%0d.%0d.%0d.%0d - - [10/Oct] \"GET /%s\" 200",
				$urandom_range(1, 255), $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), rand_text(2));
			6: s = csv_line(fields, sep);
			default: s = rand_text($urandom_range(0, 12));
		endcase
		// occasional damage: cut the line short
		if ($urandom_range(0, 9) == 0 && s.len() > 2) s = s.substr(0, $urandom_range(0, s.len() - 2));
		return s;
	endfunction

	task automatic random_file();
		int kind, lines, fields, r;
		string sep, pre, post;
		kind = $urandom_range(0, 9);
		r = $urandom_range(0, 2);
		sep = (r == 0) ? "," : (r == 1) ? "\t" : ";";
		fields = $urandom_range(2, 4);
		if (kind == 8) begin
			// raw noise, every byte value possible
			repeat ($urandom_range(1, 30)) fbuf.insert(fbuf.size(), 8'($urandom_range(0, 255)));
		end else if (kind == 9) begin
			case ($urandom_range(0, 3))
				0: push_text("PK");
				1: begin
					fbuf.insert(fbuf.size(), 8'hD4);
					fbuf.insert(fbuf.size(), 8'hC3);
				end
				2: push_text("ElfFil");
				default: fbuf.insert(fbuf.size(), 8'h0A);
			endcase
			repeat ($urandom_range(0, 8)) fbuf.insert(fbuf.size(), 8'($urandom_range(0, 255)));
		end else begin
			lines = $urandom_range(1, 3);
			for (int i = 0; i < lines; i++) begin
				pre = ($urandom_range(0, 4) == 0) ? " \t" : "";
				post = ($urandom_range(0, 3) == 0) ? "\t \r" : "";
				if ($urandom_range(0, 9) == 0) push_text(" \t");
				else push_text({pre, make_line(($urandom_range(0, 5) == 0) ?
					$urandom_range(0, 7) : kind, fields, sep), post});
				if (i < lines - 1 || $urandom_range(0, 1)) fbuf.insert(fbuf.size(), CH_LF);
			end
		end
		send_file();
	endtask

	task automatic directed_files();
		push_text("ElfFile"); fbuf.insert(fbuf.size(), 8'h00); push_text("x"); send_file();
		fbuf = '{8'hD4, 8'hC3, 8'hB2, 8'hA1, 8'h00}; send_file();
		fbuf = '{8'hA1, 8'hB2, 8'hC3, 8'hD4}; send_file();
		fbuf = '{8'h0A, 8'h0D, 8'h0D, 8'h0A, 8'hFF}; send_file();
		fbuf = '{8'h50, 8'h4B, 8'h03, 8'h04}; send_file();
		push_text("abc"); send_file();
		fbuf = '{8'hFF}; send_file();
		push_text("CEF:1\nx CEF:2\n"); send_file();
		push_text("<13>a\n<1>b"); send_file();
		push_text("Jan 1\nDec 2\n"); send_file();
		push_text("{a}\n {b} \r\n"); send_file();
		push_text("#Fields: x\n"); send_file();
		push_text("1.2.3.4 - - [x] \"GET\" 1\n10.0.0.1 - [y] \"P\"\n"); send_file();
		push_text("a,b\t\n\"c,d\",e\nf,g\t\t\nh\ti\n"); send_file();
		push_text("x;y\t\n\n\n"); send_file();
	endtask

	task automatic drain();
		while (pending_bytes.size() > 0 || in_valid || expected_codes.size() > 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		bit [5:0] settings[6][3];
		settings = '{'{6'd2, 6'd3, 6'd50}, '{6'd1, 6'd1, 6'd63}, '{6'd63, 6'd63, 6'd1},
			'{6'd0, 6'd0, 6'd0}, '{6'd1, 6'd2, 6'd3}, '{6'd2, 6'd3, 6'd5}};
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cfg_votes = 6'd2; cfg_csv_min = 6'd3; cfg_max_lines = 6'd50;
		reset_file();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		directed_files();
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 4) begin
				settings[ph][0] = 6'($urandom_range(1, 4));
				settings[ph][2] = 6'($urandom_range(1, 20));
			end
			write_reg(REG_MIN_VOTES, settings[ph][0]);
			write_reg(REG_CSV_MIN, settings[ph][1]);
			write_reg(REG_MAX_SAMPLES, settings[ph][2]);
			calm = (ph == 2);
			repeat (2) random_file();
			drain();
		end
		if (errors == 0)
			$display("PASS log_format_classifier");
		else
			$display("FAIL log_format_classifier");
		$finish;
	end

endmodule
